// File: design/srv_pkg.sv
// Shared widths, register indexes, limits and carry bundles for the repulsion pipeline.
`timescale 1ns / 1ps
`default_nettype none
package srv_pkg;

   localparam int COORD_W  = 32;
   localparam int LEN_W    = 31;
   localparam int GAIN_W   = 32;
   localparam int PUSH_W   = 48;
   localparam int MAG_W    = 33;
   localparam int SUM_W    = 66;
   localparam int ROOT_BITS = 34;
   localparam int QUO_BITS = 48;
   localparam int DEN_W    = 158;
   localparam int NUM_W    = 97;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_INFLUENCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN      = 2'd1;

   localparam logic [LEN_W-1:0]  INFLUENCE_RESET = 31'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET      = 32'd65536;
   localparam logic [LEN_W-1:0]  CLEAR_FLOOR     = 31'd7;

   localparam logic [PUSH_W-1:0] PUSH_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [PUSH_W-1:0] PUSH_MIN = 48'h8000_0000_0000;

   // carried alongside the square root
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [31:0]           prot;
   } root_side_type;

   // carried through the product stages
   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic                  flip;
      logic                  live;
      logic [ROOT_BITS-1:0]  radial;
   } post_side_type;

   // carried through the divider
   typedef struct packed {
      logic [2:0] neg;
      logic       flip;
      logic       live;
      logic [2:0] ovf;
   } quo_side_type;

endpackage
`default_nettype wire

// File: design/srv_ifs.sv
// Valid/ready channel interfaces: item in, result out, register writes.
`timescale 1ns / 1ps
`default_nettype none
interface srv_req_if import srv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] point_z;
   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   logic signed [COORD_W-1:0] center_z;
   logic [LEN_W-1:0]          sphere_radius;
   logic [LEN_W-1:0]          safety_pad;
   modport source (output valid, point_x, point_y, point_z, center_x, center_y, center_z,
                   sphere_radius, safety_pad, input ready);
   modport sink   (input valid, point_x, point_y, point_z, center_x, center_y, center_z,
                   sphere_radius, safety_pad, output ready);
endinterface

interface srv_rsp_if import srv_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [PUSH_W-1:0] push_x;
   logic signed [PUSH_W-1:0] push_y;
   logic signed [PUSH_W-1:0] push_z;
   logic                     in_range;
   logic                     clipped;
   modport source (output valid, push_x, push_y, push_z, in_range, clipped, input ready);
   modport sink   (input valid, push_x, push_y, push_z, in_range, clipped, output ready);
endinterface

interface srv_csr_if import srv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/sphere_repulsive_velocity.sv
// Top level: pipelined sphere repulsion velocity (offset, sqrt, products, long division).
//
//   channel   | dir | beat payload                                   | handshake
//   ----------+-----+------------------------------------------------+------------
//   req_bus   | in  | point xyz, center xyz, sphere_radius, safety_pad | valid/ready
//   rsp_bus   | out | push xyz (Q32.16), in_range, clipped            | valid/ready
//   csr_bus   | in  | index, data (influence range, gain)            | valid/ready
//
// One beat enters per cycle while the pipeline is not full and held by the output; the
// datapath holds a 34-step square root and a 48-step quotient, one bit per register stage.
// Reset (synchronous) clears the stage valid bits and restores both registers.
// Each full stage holds while the one after it is holding; bubbles close up,
// so the front keeps taking beats while a result waits at the output register.
// csr_bus is always ready; writes are registered.
`timescale 1ns / 1ps
`default_nettype none
module sphere_repulsive_velocity import srv_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   srv_csr_if.sink    csr_bus,
   srv_req_if.sink    req_bus,
   srv_rsp_if.source  rsp_bus
);

   // stage map
   localparam int ST_DIFF  = 0;
   localparam int ST_SQ    = 1;
   localparam int ST_SUM   = 2;
   localparam int ST_ROOT  = 3;
   localparam int ST_CLR   = ST_ROOT + ROOT_BITS;
   localparam int ST_CLAMP = ST_CLR + 1;
   localparam int ST_P1    = ST_CLR + 2;
   localparam int ST_P2    = ST_CLR + 3;
   localparam int ST_P3    = ST_CLR + 4;
   localparam int ST_P4    = ST_CLR + 5;
   localparam int ST_P5    = ST_CLR + 6;
   localparam int ST_P6    = ST_CLR + 7;
   localparam int ST_DEN   = ST_CLR + 8;
   localparam int ST_OVF   = ST_CLR + 9;
   localparam int ST_DIV   = ST_OVF + 1;
   localparam int ST_OUT   = ST_DIV + QUO_BITS;
   localparam int NST      = ST_OUT + 1;

   // ---------------- registers ----------------
   logic [LEN_W-1:0]  infl_ff;
   logic [GAIN_W-1:0] gain_ff;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         infl_ff <= INFLUENCE_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_INFLUENCE: infl_ff <= csr_bus.data[LEN_W-1:0];
            CSR_GAIN:      gain_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   // ---------------- stage flow control ----------------
   // A stage loads when it or any stage after it up to the output is empty, or when the output
   // is being taken; i.e. when some slot at or after it is free or frees up this cycle.
   logic [NST-1:0] vld_ff, vld_in, go;

   always_comb begin
      for (int i = 0; i < NST; i++) begin
         go[i] = rsp_bus.ready || ((vld_ff | ~({NST{1'b1}} << i)) != {NST{1'b1}});
      end
      vld_in[0] = go[0] ? req_bus.valid : vld_ff[0];
      for (int i = 1; i < NST; i++) begin
         vld_in[i] = go[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_bus.ready = go[ST_DIFF];

   // ---------------- offsets ----------------
   logic signed [COORD_W-1:0] pt [3];
   logic signed [COORD_W-1:0] ct [3];
   root_side_type sd0_in, sd0_ff, sd1_ff, sd2_ff;

   assign pt[0] = req_bus.point_x;
   assign pt[1] = req_bus.point_y;
   assign pt[2] = req_bus.point_z;
   assign ct[0] = req_bus.center_x;
   assign ct[1] = req_bus.center_y;
   assign ct[2] = req_bus.center_z;

   always_comb begin
      logic signed [MAG_W-1:0] off;
      for (int a = 0; a < 3; a++) begin
         off = MAG_W'(pt[a]) - MAG_W'(ct[a]);
         sd0_in.neg[a] = off[MAG_W-1];
         sd0_in.mag[a] = off[MAG_W-1] ? MAG_W'(-off) : MAG_W'(off);
      end
      sd0_in.prot = 32'(req_bus.sphere_radius) + 32'(req_bus.safety_pad);
   end

   always_ff @(posedge clock) begin
      if (go[ST_DIFF]) sd0_ff <= sd0_in;
   end

   // ---------------- squares and sum ----------------
   logic [SUM_W-1:0] sq_ff [3];
   logic [SUM_W-1:0] sq_in [3];
   logic [SUM_W-1:0] sum_ff, sum_in;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq_in[a] = SUM_W'(sd0_ff.mag[a]) * SUM_W'(sd0_ff.mag[a]);
      end
      sum_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   always_ff @(posedge clock) begin
      if (go[ST_SQ]) begin
         sq_ff  <= sq_in;
         sd1_ff <= sd0_ff;
      end
      if (go[ST_SUM]) begin
         sum_ff <= sum_in;
         sd2_ff <= sd1_ff;
      end
   end

   // ---------------- square root, one result bit per stage ----------------
   logic [SUM_W-1:0]     rt_rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] rt_root_ff [ROOT_BITS];
   root_side_type        rt_side_ff [ROOT_BITS];

   for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
      localparam int B = ROOT_BITS - 1 - j;
      logic [SUM_W-1:0]     rem_p, rem_in;
      logic [ROOT_BITS-1:0] root_p, root_in;
      root_side_type        side_p;
      logic [SUM_W+1:0]     trial;
      logic                 ge;

      if (j == 0) begin : g_first
         assign rem_p  = sum_ff;
         assign root_p = '0;
         assign side_p = sd2_ff;
      end else begin : g_next
         assign rem_p  = rt_rem_ff[j-1];
         assign root_p = rt_root_ff[j-1];
         assign side_p = rt_side_ff[j-1];
      end

      always_comb begin
         trial = ((SUM_W+2)'(root_p) << (B + 1)) | ((SUM_W+2)'(1) << (2 * B));
         ge    = (SUM_W+2)'(rem_p) >= trial;
         rem_in  = ge ? SUM_W'((SUM_W+2)'(rem_p) - trial) : rem_p;
         root_in = root_p;
         if (ge) root_in[B] = 1'b1;
      end

      always_ff @(posedge clock) begin
         if (go[ST_ROOT+j]) begin
            rt_rem_ff[j]  <= rem_in;
            rt_root_ff[j] <= root_in;
            rt_side_ff[j] <= side_p;
         end
      end
   end

   // ---------------- clearance and range test ----------------
   logic signed [35:0] clr_in, clr_ff;
   post_side_type      ps0_in, ps0_ff;

   always_comb begin
      logic [ROOT_BITS-1:0] root_val;
      root_val = rt_root_ff[ROOT_BITS-1];
      clr_in = 36'(root_val) - 36'(rt_side_ff[ROOT_BITS-1].prot);
      ps0_in.mag    = rt_side_ff[ROOT_BITS-1].mag;
      ps0_in.neg    = rt_side_ff[ROOT_BITS-1].neg;
      ps0_in.flip   = 1'b0;
      ps0_in.radial = root_val;
      ps0_in.live = (root_val != '0) && (infl_ff != '0) && (clr_in < $signed(36'(infl_ff)));
   end

   always_ff @(posedge clock) begin
      if (go[ST_CLR]) begin
         clr_ff <= clr_in;
         ps0_ff <= ps0_in;
      end
   end

   // ---------------- floor, (D - c) ----------------
   logic [LEN_W-1:0] c1_in, c1_ff;
   logic [31:0]      dm1_in, dm1_ff;
   post_side_type    ps1_in, ps1_ff;

   always_comb begin
      logic signed [31:0] dd;
      c1_in  = (clr_ff < $signed(36'(CLEAR_FLOOR))) ? CLEAR_FLOOR : clr_ff[LEN_W-1:0];
      dd     = 32'(infl_ff) - 32'(c1_in);
      dm1_in = dd[31] ? 32'(-dd) : 32'(dd);
      ps1_in = ps0_ff;
      ps1_in.flip = dd[31];
   end

   always_ff @(posedge clock) begin
      if (go[ST_CLAMP]) begin
         c1_ff  <= c1_in;
         dm1_ff <= dm1_in;
         ps1_ff <= ps1_in;
      end
   end

   // ---------------- c^2, gain*(D-c) ----------------
   logic [61:0]      c2_ff;
   logic [LEN_W-1:0] cc2_ff;
   logic [63:0]      gm2_ff;
   post_side_type    ps2_ff;

   always_ff @(posedge clock) begin
      if (go[ST_P1]) begin
         c2_ff  <= 62'(c1_ff) * 62'(c1_ff);
         cc2_ff <= c1_ff;
         gm2_ff <= 64'(gain_ff) * 64'(dm1_ff);
         ps2_ff <= ps1_ff;
      end
   end

   // ---------------- partial products: c^3 and numerators ----------------
   logic [61:0]   c3a_ff, c3b_ff;
   logic [64:0]   nlo_ff [3];
   logic [64:0]   nhi_ff [3];
   post_side_type ps3_ff;

   always_ff @(posedge clock) begin
      if (go[ST_P2]) begin
         c3a_ff <= 62'(c2_ff[30:0]) * 62'(cc2_ff);
         c3b_ff <= 62'(c2_ff[61:31]) * 62'(cc2_ff);
         for (int a = 0; a < 3; a++) begin
            nlo_ff[a] <= 65'(gm2_ff[31:0]) * 65'(ps2_ff.mag[a]);
            nhi_ff[a] <= 65'(gm2_ff[63:32]) * 65'(ps2_ff.mag[a]);
         end
         ps3_ff <= ps2_ff;
      end
   end

   logic [92:0]      c3_ff;
   logic [NUM_W-1:0] m4_ff [3];
   post_side_type    ps4_ff;

   always_ff @(posedge clock) begin
      if (go[ST_P3]) begin
         c3_ff <= 93'(c3a_ff) + (93'(c3b_ff) << 31);
         for (int a = 0; a < 3; a++) begin
            m4_ff[a] <= NUM_W'(nlo_ff[a]) + (NUM_W'(nhi_ff[a]) << 32);
         end
         ps4_ff <= ps3_ff;
      end
   end

   // ---------------- c^3 * D ----------------
   logic [61:0]      cd_ff [3];
   logic [NUM_W-1:0] m5_ff [3];
   post_side_type    ps5_ff;

   always_ff @(posedge clock) begin
      if (go[ST_P4]) begin
         cd_ff[0] <= 62'(c3_ff[30:0])  * 62'(infl_ff);
         cd_ff[1] <= 62'(c3_ff[61:31]) * 62'(infl_ff);
         cd_ff[2] <= 62'(c3_ff[92:62]) * 62'(infl_ff);
         m5_ff    <= m4_ff;
         ps5_ff   <= ps4_ff;
      end
   end

   logic [123:0]     c3d_ff;
   logic [NUM_W-1:0] m6_ff [3];
   post_side_type    ps6_ff;

   always_ff @(posedge clock) begin
      if (go[ST_P5]) begin
         c3d_ff <= 124'(cd_ff[0]) + (124'(cd_ff[1]) << 31) + (124'(cd_ff[2]) << 62);
         m6_ff  <= m5_ff;
         ps6_ff <= ps5_ff;
      end
   end

   // ---------------- times distance ----------------
   logic [64:0]      e_ff [4];
   logic [NUM_W-1:0] m7_ff [3];
   post_side_type    ps7_ff;

   always_ff @(posedge clock) begin
      if (go[ST_P6]) begin
         e_ff[0] <= 65'(c3d_ff[30:0])   * 65'(ps6_ff.radial);
         e_ff[1] <= 65'(c3d_ff[61:31])  * 65'(ps6_ff.radial);
         e_ff[2] <= 65'(c3d_ff[92:62])  * 65'(ps6_ff.radial);
         e_ff[3] <= 65'(c3d_ff[123:93]) * 65'(ps6_ff.radial);
         m7_ff   <= m6_ff;
         ps7_ff  <= ps6_ff;
      end
   end

   logic [DEN_W-1:0] den8_ff;
   logic [NUM_W-1:0] m8_ff [3];
   post_side_type    ps8_ff;

   always_ff @(posedge clock) begin
      if (go[ST_DEN]) begin
         den8_ff <= DEN_W'(e_ff[0]) + (DEN_W'(e_ff[1]) << 31)
                  + (DEN_W'(e_ff[2]) << 62) + (DEN_W'(e_ff[3]) << 93);
         m8_ff   <= m7_ff;
         ps8_ff  <= ps7_ff;
      end
   end

   // ---------------- overflow check: quotient >= 2^48 iff M >= den ----------------
   logic [DEN_W-1:0] den9_ff;
   logic [DEN_W-1:0] rem9_ff [3];
   quo_side_type     qs9_in, qs9_ff;

   always_comb begin
      qs9_in.neg  = ps8_ff.neg;
      qs9_in.flip = ps8_ff.flip;
      qs9_in.live = ps8_ff.live;
      for (int a = 0; a < 3; a++) begin
         qs9_in.ovf[a] = DEN_W'(m8_ff[a]) >= den8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go[ST_OVF]) begin
         den9_ff <= den8_ff;
         for (int a = 0; a < 3; a++) begin
            rem9_ff[a] <= DEN_W'(m8_ff[a]);
         end
         qs9_ff <= qs9_in;
      end
   end

   // ---------------- restoring division, one quotient bit per stage ----------------
   logic [DEN_W-1:0]    dv_rem_ff  [QUO_BITS][3];
   logic [QUO_BITS-1:0] dv_quo_ff  [QUO_BITS][3];
   logic [DEN_W-1:0]    dv_den_ff  [QUO_BITS];
   quo_side_type        dv_side_ff [QUO_BITS];

   for (genvar j = 0; j < QUO_BITS; j++) begin : g_div
      logic [DEN_W-1:0]    rem_p [3];
      logic [QUO_BITS-1:0] quo_p [3];
      logic [DEN_W-1:0]    rem_in [3];
      logic [QUO_BITS-1:0] quo_in [3];
      logic [DEN_W-1:0]    den_p;
      quo_side_type        side_p;

      if (j == 0) begin : g_first
         assign rem_p  = rem9_ff;
         assign quo_p  = '{default: '0};
         assign den_p  = den9_ff;
         assign side_p = qs9_ff;
      end else begin : g_next
         assign rem_p  = dv_rem_ff[j-1];
         assign quo_p  = dv_quo_ff[j-1];
         assign den_p  = dv_den_ff[j-1];
         assign side_p = dv_side_ff[j-1];
      end

      always_comb begin
         logic [DEN_W:0] twice;
         logic           ge;
         for (int a = 0; a < 3; a++) begin
            twice     = {rem_p[a], 1'b0};
            ge        = twice >= (DEN_W+1)'(den_p);
            rem_in[a] = ge ? DEN_W'(twice - (DEN_W+1)'(den_p)) : DEN_W'(twice);
            quo_in[a] = {quo_p[a][QUO_BITS-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (go[ST_DIV+j]) begin
            dv_rem_ff[j]  <= rem_in;
            dv_quo_ff[j]  <= quo_in;
            dv_den_ff[j]  <= den_p;
            dv_side_ff[j] <= side_p;
         end
      end
   end

   // ---------------- sign, saturation, zero vector; output register ----------------
   logic [PUSH_W-1:0] push_in [3];
   logic [PUSH_W-1:0] push_ff [3];
   logic              in_range_in, in_range_ff, clipped_in, clipped_ff;

   always_comb begin
      quo_side_type        side;
      logic [QUO_BITS-1:0] q;
      logic                toward;
      side        = dv_side_ff[QUO_BITS-1];
      clipped_in  = 1'b0;
      in_range_in = side.live;
      for (int a = 0; a < 3; a++) begin
         q      = dv_quo_ff[QUO_BITS-1][a];
         toward = side.neg[a] ^ side.flip;
         push_in[a] = '0;
         if (side.live) begin
            if (toward) begin
               if (side.ovf[a] || (q > PUSH_MIN)) begin
                  push_in[a] = PUSH_MIN;
                  clipped_in = 1'b1;
               end else begin
                  push_in[a] = PUSH_W'(-q);
               end
            end else begin
               if (side.ovf[a] || (q > PUSH_MAX)) begin
                  push_in[a] = PUSH_MAX;
                  clipped_in = 1'b1;
               end else begin
                  push_in[a] = q;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go[ST_OUT]) begin
         push_ff     <= push_in;
         in_range_ff <= in_range_in;
         clipped_ff  <= clipped_in;
      end
   end

   assign rsp_bus.valid    = vld_ff[ST_OUT];
   assign rsp_bus.push_x   = push_ff[0];
   assign rsp_bus.push_y   = push_ff[1];
   assign rsp_bus.push_z   = push_ff[2];
   assign rsp_bus.in_range = in_range_ff;
   assign rsp_bus.clipped  = clipped_ff;

endmodule
`default_nettype wire

// File: design/srv_checker.sv
// Port-level checks on the result channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module srv_checker import srv_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [PUSH_W-1:0] push_x,
   input wire logic [PUSH_W-1:0] push_y,
   input wire logic [PUSH_W-1:0] push_z,
   input wire logic              in_range,
   input wire logic              clipped
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !in_range) |-> (push_x == '0 && push_y == '0 && push_z == '0 && !clipped))
      else $error("out of range beat carries a nonzero push or clip");

   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && clipped) |-> (in_range &&
         (push_x == PUSH_MAX || push_x == PUSH_MIN || push_y == PUSH_MAX ||
          push_y == PUSH_MIN || push_z == PUSH_MAX || push_z == PUSH_MIN)))
      else $error("clip flag without a component at a rail");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(push_x) && $stable(push_y) &&
         $stable(push_z) && $stable(in_range) && $stable(clipped)))
      else $error("stalled result beat changed");

endmodule

bind sphere_repulsive_velocity srv_checker u_srv_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .push_x    (rsp_bus.push_x),
   .push_y    (rsp_bus.push_y),
   .push_z    (rsp_bus.push_z),
   .in_range  (rsp_bus.in_range),
   .clipped   (rsp_bus.clipped)
);
`default_nettype wire

// File: tb/sv/srv_repulsion_checker.sv
// Checker: predicts each repulsion result from accepted beats and compares it with the output.
`timescale 1ns / 1ps
`default_nettype none
module srv_repulsion_checker import srv_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   srv_csr_if        csr,
   srv_req_if        req,
   srv_rsp_if        rsp,
   output int        fail_count,
   output int        pending,
   output int        hit_count,
   output int        clip_count
);

   typedef struct packed {
      logic signed [PUSH_W-1:0] x;
      logic signed [PUSH_W-1:0] y;
      logic signed [PUSH_W-1:0] z;
      logic                     in_range;
      logic                     clipped;
   } push_type;

   logic [LEN_W-1:0]  influence;
   logic [GAIN_W-1:0] gain;
   push_type          push_q[$];

   function automatic push_type repel(input logic signed [COORD_W-1:0] px, py, pz, cx, cy, cz,
                                      input logic [LEN_W-1:0] rad, pad);
      logic signed [33:0] off[3];
      logic [32:0]        mag[3];
      logic [69:0]        acc;
      logic [69:0]        sq;
      logic [33:0]        root;
      logic [33:0]        cand;
      logic [31:0]        prot;
      logic signed [39:0] clr;
      logic signed [39:0] span;
      logic [199:0]       cu;
      logic [199:0]       smag;
      logic [199:0]       num;
      logic [199:0]       den;
      logic [199:0]       quo;
      logic               flip;
      logic               neg;
      logic [PUSH_W-1:0]  comp[3];
      push_type           res;
      res = '0;
      off[0] = $signed(px) - $signed(cx);
      off[1] = $signed(py) - $signed(cy);
      off[2] = $signed(pz) - $signed(cz);
      acc = '0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = off[k] < 0 ? 33'(-off[k]) : 33'(off[k]);
         acc = acc + 70'(mag[k]) * 70'(mag[k]);
      end
      root = '0;
      for (int b = ROOT_BITS - 1; b >= 0; b--) begin
         cand = root | (34'd1 << b);
         sq = 70'(cand) * 70'(cand);
         if (sq <= acc) root = cand;
      end
      prot = 32'(rad) + 32'(pad);
      clr = $signed({6'b0, root}) - $signed({8'b0, prot});
      if (root == 0 || influence == 0 || clr >= $signed({9'b0, influence})) return res;
      // clearance floor, then sign of (1/c - 1/D)
      if (clr < 7) clr = 7;
      span = $signed({9'b0, influence}) - clr;
      flip = span < 0;
      smag = flip ? 200'(-span) : 200'(span);
      cu = 200'(clr);
      den = cu * cu * cu * 200'(influence) * 200'(root);
      for (int k = 0; k < 3; k++) begin
         neg = (off[k] < 0) != flip;
         num = (200'(gain) * smag * 200'(mag[k])) << 48;
         quo = num / den;
         if (neg) begin
            if (quo > 200'(PUSH_MIN)) begin
               quo = 200'(PUSH_MIN);
               res.clipped = 1'b1;
            end
            comp[k] = -quo[PUSH_W-1:0];
         end else begin
            if (quo > 200'(PUSH_MAX)) begin
               quo = 200'(PUSH_MAX);
               res.clipped = 1'b1;
            end
            comp[k] = quo[PUSH_W-1:0];
         end
      end
      res.x = comp[0];
      res.y = comp[1];
      res.z = comp[2];
      res.in_range = 1'b1;
      return res;
   endfunction

   always @(posedge clock) begin
      push_type want;
      if (reset) begin
         influence <= INFLUENCE_RESET;
         gain <= GAIN_RESET;
         push_q.delete();
         pending <= 0;
         fail_count <= 0;
         hit_count <= 0;
         clip_count <= 0;
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_INFLUENCE) influence <= csr.data[LEN_W-1:0];
            else if (csr.index == CSR_GAIN) gain <= csr.data;
         end
         if (req.valid && req.ready)
            push_q.insert(push_q.size(),
                          repel(req.point_x, req.point_y, req.point_z, req.center_x,
                                req.center_y, req.center_z, req.sphere_radius,
                                req.safety_pad));
         if (rsp.valid && rsp.ready) begin
            if (push_q.size() == 0) begin
               $display("%0t: unexpected result beat push %h %h %h", $time,
                        rsp.push_x, rsp.push_y, rsp.push_z);
               fail_count <= fail_count + 1;
            end else begin
               want = push_q.pop_front();
               if (want != {rsp.push_x, rsp.push_y, rsp.push_z, rsp.in_range, rsp.clipped})
               begin
                  $display("%0t: mismatch expected x=%h y=%h z=%h in=%b clip=%b", $time,
                           want.x, want.y, want.z, want.in_range, want.clipped);
                  $display("%0t:          actual   x=%h y=%h z=%h in=%b clip=%b", $time,
                           rsp.push_x, rsp.push_y, rsp.push_z, rsp.in_range, rsp.clipped);
                  fail_count <= fail_count + 1;
               end
               if (want.in_range) hit_count <= hit_count + 1;
               if (want.clipped) clip_count <= clip_count + 1;
            end
         end
         pending <= push_q.size();
      end
   end

endmodule
`default_nettype wire

// File: tb/sv/tb_sphere_repulsive_velocity.sv
// Testbench top: stimulus, config phases, output stalls, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_sphere_repulsive_velocity;
   import srv_pkg::*;

   localparam int WATCHDOG = 20000;
   localparam int DRAIN    = 200;   // extra wait once no results are pending

   logic clock;
   logic reset;
   logic quiet;                     // no idling in the closing stretch
   int   fail_count, pending, hit_count, clip_count;
   int   idle_cycles;
   int   sent;

   srv_csr_if csr_bus ();
   srv_req_if req_bus ();
   srv_rsp_if rsp_bus ();

   sphere_repulsive_velocity u_dut (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   srv_repulsion_checker u_check (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_bus),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .fail_count (fail_count),
      .pending    (pending),
      .hit_count  (hit_count),
      .clip_count (clip_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Random bit width so small and huge magnitudes both show up often.
   function automatic logic [31:0] rbits();
      int w;
      w = $urandom_range(0, 32);
      return $urandom & 32'((33'd1 << w) - 1);
   endfunction

   // Sink side: ready drops in random bursts, none once quiet is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Watchdog: cycles without any beat on either data channel.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("%0t: watchdog expired, %0d results outstanding", $time, pending);
         $display("sphere_repulsive_velocity test failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= val;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // One beat; valid stays high into the next beat unless a gap is drawn.
   task automatic send(input logic [31:0] px, py, pz, cx, cy, cz,
                       input logic [30:0] rad, pad);
      req_bus.valid         <= 1'b1;
      req_bus.point_x       <= px;
      req_bus.point_y       <= py;
      req_bus.point_z       <= pz;
      req_bus.center_x      <= cx;
      req_bus.center_y      <= cy;
      req_bus.center_z      <= cz;
      req_bus.sphere_radius <= rad;
      req_bus.safety_pad    <= pad;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Mostly point-near-sphere pairs sized around the scale k, some pure noise.
   task automatic send_random();
      int          k;
      logic [31:0] cx, cy, cz;
      logic [31:0] ox, oy, oz;
      if ($urandom_range(0, 4) == 0) begin
         send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              31'($urandom), 31'($urandom));
      end else begin
         k  = $urandom_range(1, 22);
         cx = $urandom >> $urandom_range(1, 31);
         cy = $urandom >> $urandom_range(1, 31);
         cz = $urandom >> $urandom_range(1, 31);
         if ($urandom_range(0, 1)) cx = -cx;
         ox = $urandom_range(0, 1 << k) - (1 << (k - 1));
         oy = $urandom_range(0, 1 << k) - (1 << (k - 1));
         oz = $urandom_range(0, 1 << k) - (1 << (k - 1));
         send(cx + ox, cy + oy, cz + oz, cx, cy, cz,
              31'($urandom_range(0, 1 << (k - 1))), 31'(rbits() >> (32 - k)));
      end
   endtask

   // Stop offering beats, then wait for every result to come back.
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   initial begin
      logic [31:0] infl_set[6];
      logic [31:0] gain_set[6];
      reset <= 1'b1;
      quiet <= 1'b0;
      sent = 0;
      req_bus.valid <= 1'b0;
      req_bus.point_x <= '0;
      req_bus.point_y <= '0;
      req_bus.point_z <= '0;
      req_bus.center_x <= '0;
      req_bus.center_y <= '0;
      req_bus.center_z <= '0;
      req_bus.sphere_radius <= '0;
      req_bus.safety_pad <= '0;
      csr_bus.valid <= 1'b0;
      csr_bus.index <= CSR_INFLUENCE;
      csr_bus.data  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed beats under reset-default registers (D = 1.0, gain = 1.0).
      send(0, 0, 0, 0, 0, 0, 31'd0, 31'd0);                       // zero offset
      send(32'h1234, 32'h5, 32'h7, 32'h1234, 32'h5, 32'h7,
           31'd0, 31'd0);                                          // same point, nonzero
      send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           31'd0, 31'd0);                                          // widest offset
      send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
           31'h7FFF_FFFF, 31'h7FFF_FFFF);                          // max radius and pad
      send(32'd1, 0, 0, 0, 0, 0, 31'd0, 31'd0);                    // 1 LSB away: saturates
      send(0, -32'sd1, 0, 0, 0, 0, 31'd0, 31'd0);
      send(0, 0, 32'd3, 0, 0, 0, 31'd1, 31'd1);                   // close to surface, floor
      send(32'd20000, 32'd20000, 0, 0, 0, 0, 31'd100, 31'd50);
      send(32'd65536, 0, 0, 0, 0, 0, 31'd0, 31'd0);               // clearance equal to D
      send(32'd65535, 0, 0, 0, 0, 0, 31'd0, 31'd0);               // just inside D
      send(32'd70000, 0, 0, 0, 0, 0, 31'd10000, 31'd0);
      send(-32'sd40000, 32'd30000, -32'sd20000, 0, 0, 0, 31'd30000, 31'd5000);
      send(32'd9, 32'd9, 32'd9, 0, 0, 0, 31'd8, 31'd0);            // clearance at the floor
      send(32'h7FFF_0000, 0, 0, 32'h7FFE_8000, 0, 0, 31'd16384, 31'd16384);
      repeat (180) send_random();
      drain();

      // Register phases: smallest, below the floor, zero, zero gain, largest, random.
      infl_set = '{32'd1, 32'd3, 32'd0, 32'd131072, 32'h7FFF_FFFF, $urandom};
      gain_set = '{32'hFFFF_FFFF, 32'd65536, 32'd65536, 32'd0, 32'hFFFF_FFFF, $urandom};
      foreach (infl_set[p]) begin
         write_reg(CSR_INFLUENCE, infl_set[p]);
         write_reg(CSR_GAIN, gain_set[p]);
         send(32'd2, 0, 0, 0, 0, 0, 31'd0, 31'd0);
         send(0, 0, 32'd5, 0, 0, 0, 31'd1, 31'd0);
         if (p == 5) quiet <= 1'b1;
         repeat (p == 4 ? 200 : 220) send_random();
         drain();
      end

      $display("%0d beats over seven register settings: %0d in range, %0d saturated",
               sent, hit_count, clip_count);
      if (fail_count == 0)
         $display("sphere_repulsive_velocity test passed");
      else
         $display("sphere_repulsive_velocity test failed");
      $finish;
   end

endmodule
`default_nettype wire
